>>> src/ptg_pkg.sv
// ============================================================================
// ptg_pkg: shared constants for the periodic triangle geometry core
// Register indexes, fixed output formats and the quotient width of the
// pipelined dividers.
// ============================================================================
package ptg_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam int BOX_W     = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X = 8'd0,
        REG_BOX_Y = 8'd1
    } t_cfg_reg;

    localparam logic [BOX_W-1:0] BOX_RESET = 24'd655360;

    // Output formats
    localparam int AREA_W     = 48;
    localparam int AREA_SHIFT = 17;
    localparam int NORM_W     = 24;
    localparam int NORM_FRAC  = 22;
    localparam int COT_W      = 32;
    localparam int COT_FRAC   = 16;
    localparam int EDGE_W     = 32;

    localparam logic signed [NORM_W-1:0] NORM_ONE = 24'sd4194304;
    localparam logic [COT_W-1:0]         COT_MAX  = 32'h7FFF_FFFF;
    localparam logic [COT_W-1:0]         COT_MIN  = 32'h8000_0000;

    // One quotient bit per divider stage
    localparam int QUOT_W = 32;

endpackage

>>> src/periodic_triangle_geometry_core.sv
// ============================================================================
// periodic_triangle_geometry_core: area, normal and cotangent of a triangle
// Minimum-image wrap in a periodic box, cross and dot products, pipelined
// square roots and dividers.
// ============================================================================
// The core accepts one triangle per clock while the output is not stalled
// and returns one result per triangle in order. A request passes through
// nine arithmetic stages, the bit-serial square-root pipeline (2*E+1
// stages, where E = max(25, COORD_WIDTH+1)), one area and overflow stage,
// the 32-stage divider pipeline and the output register. A stall on the
// output freezes the whole pipeline. Box lengths are written through the
// configuration port and may only change while no request is in flight.
module periodic_triangle_geometry_core import ptg_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [BOX_W-1:0]              i_cfg_data,
    // Triangle request
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [COORD_WIDTH-1:0]        i_first_x,
    input  logic [COORD_WIDTH-1:0]        i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_z,
    input  logic [COORD_WIDTH-1:0]        i_second_x,
    input  logic [COORD_WIDTH-1:0]        i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_z,
    input  logic [COORD_WIDTH-1:0]        i_third_x,
    input  logic [COORD_WIDTH-1:0]        i_third_y,
    input  logic signed [COORD_WIDTH-1:0] i_third_z,
    // Result
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [AREA_W-1:0]             o_area,
    output logic signed [NORM_W-1:0]      o_normal_x,
    output logic signed [NORM_W-1:0]      o_normal_y,
    output logic signed [NORM_W-1:0]      o_normal_z,
    output logic signed [COT_W-1:0]       o_cotangent,
    output logic [EDGE_W-1:0]             o_edge_length,
    output logic                          o_degenerate
);

    localparam int W     = COORD_WIDTH;
    localparam int EW    = (W + 1 > 25) ? W + 1 : 25;   // edge component
    localparam int PW    = BOX_W + W + 1;               // box times wrapped delta
    localparam int MW    = 2 * EW;                      // product magnitude
    localparam int CW    = MW + 1;                      // signed cross / dot
    localparam int SQ1W  = 2 * MW;                      // one squared component
    localparam int SQW   = SQ1W + 2;                    // sum of three squares
    localparam int RW    = SQW / 2;                     // root width
    localparam int NNW   = MW + NORM_FRAC;
    localparam int CNW   = MW + COT_FRAC;
    localparam int MSIDE = 4 * MW + 3;
    localparam int CSIDE = 3 + AREA_W + EDGE_W;

    // Round box * delta from Q.(W+16) to Q.16, ties away from zero
    function automatic logic signed [EW-1:0] scale_round(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] rsum;
        logic [EW-1:0] m;
        mag  = p[PW-1] ? PW'(-p) : PW'(p);
        rsum = mag + (PW'(1) << (W - 1));
        m    = EW'(rsum >> W);
        return p[PW-1] ? -m : m;
    endfunction

    logic en;
    logic r_ov;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BOX_W-1:0] r_box_x;
    logic [BOX_W-1:0] r_box_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x <= BOX_RESET;
            r_box_y <= BOX_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BOX_X: r_box_x <= i_cfg_data;
                REG_BOX_Y: r_box_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the result register is held
    assign en         = !r_ov || i_out_ready;
    assign o_in_ready = en;

    // ------------------------------------------------------------------
    // Valid bits for the front stages
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0; r_v9 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
            r_v6 <= r_v5; r_v7 <= r_v6; r_v8 <= r_v7; r_v9 <= r_v8;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: wrapped fractional deltas and height deltas
    // ------------------------------------------------------------------
    logic signed [W-1:0]  r_dx1, r_dx2, r_dy1, r_dy2;
    logic signed [EW-1:0] r_az1, r_bz1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx1 <= i_second_x - i_first_x;
            r_dx2 <= i_third_x - i_first_x;
            r_dy1 <= i_second_y - i_first_y;
            r_dy2 <= i_third_y - i_first_y;
            r_az1 <= $signed({{(EW-W){i_second_z[W-1]}}, i_second_z})
                   - $signed({{(EW-W){i_first_z[W-1]}}, i_first_z});
            r_bz1 <= $signed({{(EW-W){i_third_z[W-1]}}, i_third_z})
                   - $signed({{(EW-W){i_first_z[W-1]}}, i_first_z});
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by the box lengths
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_px1, r_px2, r_py1, r_py2;
    logic signed [EW-1:0] r_az2, r_bz2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px1 <= $signed({1'b0, r_box_x}) * r_dx1;
            r_px2 <= $signed({1'b0, r_box_x}) * r_dx2;
            r_py1 <= $signed({1'b0, r_box_y}) * r_dy1;
            r_py2 <= $signed({1'b0, r_box_y}) * r_dy2;
            r_az2 <= r_az1;
            r_bz2 <= r_bz1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round to Q.16 edge vectors
    // ------------------------------------------------------------------
    logic signed [EW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= scale_round(r_px1);
            r_bx <= scale_round(r_px2);
            r_ay <= scale_round(r_py1);
            r_by <= scale_round(r_py2);
            r_az <= r_az2;
            r_bz <= r_bz2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: cross, dot and edge products
    // ------------------------------------------------------------------
    logic signed [MW-1:0] r_crs  [0:5];
    logic signed [MW-1:0] r_dotp [0:2];
    logic signed [MW-1:0] r_esq  [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crs[0]  <= r_ay * r_bz;
            r_crs[1]  <= r_az * r_by;
            r_crs[2]  <= r_az * r_bx;
            r_crs[3]  <= r_ax * r_bz;
            r_crs[4]  <= r_ax * r_by;
            r_crs[5]  <= r_ay * r_bx;
            r_dotp[0] <= r_ax * r_bx;
            r_dotp[1] <= r_ay * r_by;
            r_dotp[2] <= r_az * r_bz;
            r_esq[0]  <= r_ax * r_ax;
            r_esq[1]  <= r_ay * r_ay;
            r_esq[2]  <= r_az * r_az;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: cross components, dot sum, squared edge length
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_c [0:2];
    logic signed [CW-1:0] r_dsum;
    logic [MW-1:0]        r_esum5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= CW'(r_crs[2*i]) - CW'(r_crs[2*i+1]);
            end
            r_dsum  <= CW'(r_dotp[0]) + CW'(r_dotp[1]) + CW'(r_dotp[2]);
            r_esum5 <= $unsigned(r_esq[0]) + $unsigned(r_esq[1]) + $unsigned(r_esq[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: magnitudes and signs
    // ------------------------------------------------------------------
    logic [MW-1:0] r_cm6 [0:2];
    logic [2:0]    r_cs6;
    logic [MW-1:0] r_dmag6;
    logic          r_dneg6;
    logic [MW-1:0] r_esum6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_cm6[i] <= r_c[i][CW-1] ? MW'(-r_c[i]) : MW'(r_c[i]);
                r_cs6[i] <= r_c[i][CW-1];
            end
            r_dmag6 <= r_dsum[CW-1] ? MW'(-r_dsum) : MW'(r_dsum);
            r_dneg6 <= r_dsum[CW-1];
            r_esum6 <= r_esum5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: partial products of the cross squares
    // ------------------------------------------------------------------
    logic [MW-1:0] r_hh [0:2];
    logic [MW-1:0] r_hl [0:2];
    logic [MW-1:0] r_ll [0:2];
    logic [MW-1:0] r_cm7 [0:2];
    logic [2:0]    r_cs7;
    logic [MW-1:0] r_dmag7;
    logic          r_dneg7;
    logic [MW-1:0] r_esum7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_hh[i]  <= r_cm6[i][MW-1:EW] * r_cm6[i][MW-1:EW];
                r_hl[i]  <= r_cm6[i][MW-1:EW] * r_cm6[i][EW-1:0];
                r_ll[i]  <= r_cm6[i][EW-1:0] * r_cm6[i][EW-1:0];
                r_cm7[i] <= r_cm6[i];
            end
            r_cs7   <= r_cs6;
            r_dmag7 <= r_dmag6;
            r_dneg7 <= r_dneg6;
            r_esum7 <= r_esum6;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: squares of each cross component
    // ------------------------------------------------------------------
    logic [SQ1W-1:0] r_sq [0:2];
    logic [MW-1:0]   r_cm8 [0:2];
    logic [2:0]      r_cs8;
    logic [MW-1:0]   r_dmag8;
    logic            r_dneg8;
    logic [MW-1:0]   r_esum8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]  <= {r_hh[i], {MW{1'b0}}} + (SQ1W'(r_hl[i]) << (EW + 1))
                          + SQ1W'(r_ll[i]);
                r_cm8[i] <= r_cm7[i];
            end
            r_cs8   <= r_cs7;
            r_dmag8 <= r_dmag7;
            r_dneg8 <= r_dneg7;
            r_esum8 <= r_esum7;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: squared cross magnitude
    // ------------------------------------------------------------------
    logic [SQW-1:0] r_tot;
    logic [MW-1:0]  r_cm9 [0:2];
    logic [2:0]     r_cs9;
    logic [MW-1:0]  r_dmag9;
    logic           r_dneg9;
    logic [MW-1:0]  r_esum9;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tot <= SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
            for (int i = 0; i < 3; i++) begin
                r_cm9[i] <= r_cm8[i];
            end
            r_cs9   <= r_cs8;
            r_dmag9 <= r_dmag8;
            r_dneg9 <= r_dneg8;
            r_esum9 <= r_esum8;
        end
    end

    // ------------------------------------------------------------------
    // Square roots: cross magnitude and edge length side by side
    // ------------------------------------------------------------------
    logic             s_mag_valid, s_edge_valid;
    logic [RW-1:0]    s_mag, s_eroot;
    logic [MSIDE-1:0] s_mside;
    logic             s_eside;
    logic [MW-1:0]    q_cm0, q_cm1, q_cm2, q_dmag;
    logic [2:0]       q_cs;

    ptg_sqrt #(
        .IN_W   (SQW),
        .SIDE_W (MSIDE)
    ) u_mag_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v9),
        .i_radicand (r_tot),
        .i_side     ({r_cm9[0], r_cm9[1], r_cm9[2], r_cs9, r_dmag9}),
        .o_valid    (s_mag_valid),
        .o_root     (s_mag),
        .o_side     (s_mside)
    );

    ptg_sqrt #(
        .IN_W   (SQW),
        .SIDE_W (1)
    ) u_edge_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v9),
        .i_radicand (SQW'(r_esum9)),
        .i_side     (r_dneg9),
        .o_valid    (s_edge_valid),
        .o_root     (s_eroot),
        .o_side     (s_eside)
    );

    assign {q_cm0, q_cm1, q_cm2, q_cs, q_dmag} = s_mside;

    // ------------------------------------------------------------------
    // Stage 10: area, edge saturation, cotangent overflow, degenerate
    // ------------------------------------------------------------------
    logic [RW:0]         asum;
    logic [RW:0]         ashift;
    logic [RW-1:0]       r_mag10;
    logic [MW-1:0]       r_cm10 [0:2];
    logic [2:0]          r_cs10;
    logic [MW-1:0]       r_dmag10;
    logic                r_dneg10;
    logic                r_ovf10;
    logic                r_degen10;
    logic [AREA_W-1:0]   r_area10;
    logic [EDGE_W-1:0]   r_edge10;

    assign asum   = (RW+1)'(s_mag) + ((RW+1)'(1) << (AREA_SHIFT - 1));
    assign ashift = asum >> AREA_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
        end else if (en) begin
            r_v10 <= s_mag_valid & s_edge_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag10   <= s_mag;
            r_cm10[0] <= q_cm0;
            r_cm10[1] <= q_cm1;
            r_cm10[2] <= q_cm2;
            r_cs10    <= q_cs;
            r_dmag10  <= q_dmag;
            r_dneg10  <= s_eside;
            r_ovf10   <= ((RW+COT_FRAC)'(q_dmag) >= {s_mag, {COT_FRAC{1'b0}}});
            r_degen10 <= (s_mag == '0);
            r_area10  <= (ashift > (RW+1)'({AREA_W{1'b1}})) ? {AREA_W{1'b1}}
                                                           : AREA_W'(ashift);
            r_edge10  <= (s_eroot > RW'({EDGE_W{1'b1}})) ? {EDGE_W{1'b1}}
                                                        : EDGE_W'(s_eroot);
        end
    end

    // ------------------------------------------------------------------
    // Dividers: three normal components and the cotangent
    // ------------------------------------------------------------------
    logic              s_nv [0:2];
    logic [QUOT_W-1:0] s_nq [0:2];
    logic [RW-1:0]     s_nr [0:2];
    logic [RW-1:0]     s_nd [0:2];
    logic              s_ns [0:2];

    for (genvar i = 0; i < 3; i++) begin : g_norm_div
        logic [NNW-1:0] num;

        assign num = {r_cm10[i], {NORM_FRAC{1'b0}}};

        ptg_div #(
            .DEN_W  (RW),
            .SIDE_W (1)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r_v10),
            .i_rem   (RW'(num >> QUOT_W)),
            .i_low   (num[QUOT_W-1:0]),
            .i_den   (r_mag10),
            .i_side  (r_cs10[i]),
            .o_valid (s_nv[i]),
            .o_quot  (s_nq[i]),
            .o_rem   (s_nr[i]),
            .o_den   (s_nd[i]),
            .o_side  (s_ns[i])
        );
    end

    logic [CNW-1:0]    cnum;
    logic              s_cv;
    logic [QUOT_W-1:0] s_cq;
    logic [RW-1:0]     s_cr, s_cd;
    logic [CSIDE-1:0]  s_cside;

    assign cnum = {r_dmag10, {COT_FRAC{1'b0}}};

    ptg_div #(
        .DEN_W  (RW),
        .SIDE_W (CSIDE)
    ) u_cot_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v10),
        .i_rem   (RW'(cnum >> QUOT_W)),
        .i_low   (cnum[QUOT_W-1:0]),
        .i_den   (r_mag10),
        .i_side  ({r_dneg10, r_ovf10, r_degen10, r_area10, r_edge10}),
        .o_valid (s_cv),
        .o_quot  (s_cq),
        .o_rem   (s_cr),
        .o_den   (s_cd),
        .o_side  (s_cside)
    );

    // ------------------------------------------------------------------
    // Final rounding, sign and saturation
    // ------------------------------------------------------------------
    logic                     f_dneg, f_ovf, f_degen;
    logic [AREA_W-1:0]        f_area;
    logic [EDGE_W-1:0]        f_edge;
    logic signed [NORM_W-1:0] n_norm [0:2];
    logic [COT_W-1:0]         n_cot;
    logic [QUOT_W:0]          qn [0:2];
    logic [QUOT_W:0]          qc;

    assign {f_dneg, f_ovf, f_degen, f_area, f_edge} = s_cside;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qn[i] = (QUOT_W+1)'(s_nq[i])
                  + (QUOT_W+1)'(s_nr[i] >= (s_nd[i] - s_nr[i]));
            if (f_degen) begin
                n_norm[i] = '0;
            end else if (s_ns[i]) begin
                n_norm[i] = -$signed(qn[i][NORM_W-1:0]);
            end else begin
                n_norm[i] = $signed(qn[i][NORM_W-1:0]);
            end
        end
        qc = (QUOT_W+1)'(s_cq) + (QUOT_W+1)'(s_cr >= (s_cd - s_cr));
        if (f_degen) begin
            n_cot = '0;
        end else if (f_dneg) begin
            n_cot = (f_ovf || qc > {1'b0, COT_MIN}) ? COT_MIN : -qc[COT_W-1:0];
        end else begin
            n_cot = (f_ovf || qc > {1'b0, COT_MAX}) ? COT_MAX : qc[COT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [AREA_W-1:0]        r_area;
    logic signed [NORM_W-1:0] r_nx, r_ny, r_nz;
    logic [COT_W-1:0]         r_cot;
    logic [EDGE_W-1:0]        r_edge;
    logic                     r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= s_cv & s_nv[0] & s_nv[1] & s_nv[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_area  <= f_degen ? '0 : f_area;
            r_nx    <= n_norm[0];
            r_ny    <= n_norm[1];
            r_nz    <= n_norm[2];
            r_cot   <= n_cot;
            r_edge  <= f_edge;
            r_degen <= f_degen;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_area        = r_area;
    assign o_normal_x    = r_nx;
    assign o_normal_y    = r_ny;
    assign o_normal_z    = r_nz;
    assign o_cotangent   = $signed(r_cot);
    assign o_edge_length = r_edge;
    assign o_degenerate  = r_degen;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_sqrt_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_mag_valid == s_edge_valid)
        else $error("square-root pipelines out of step");

    a_div_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cv == s_nv[0]) && (s_cv == s_nv[1]) && (s_cv == s_nv[2]))
        else $error("divider pipelines out of step");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |->
            (o_area == '0) && (o_normal_x == '0) && (o_normal_y == '0)
            && (o_normal_z == '0) && (o_cotangent == '0))
        else $error("degenerate result with nonzero geometry");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_normal_x <= NORM_ONE) && (o_normal_x >= -NORM_ONE)
            && (o_normal_y <= NORM_ONE) && (o_normal_y >= -NORM_ONE)
            && (o_normal_z <= NORM_ONE) && (o_normal_z >= -NORM_ONE))
        else $error("normal component beyond unit length");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

>>> src/ptg_sqrt.sv
// ============================================================================
// ptg_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage, with a
// sideband word that travels alongside each request.
// ============================================================================
module ptg_sqrt #(
    parameter int IN_W   = 102,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_radicand,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              s_valid [0:ROOT_W];
    logic [REM_W-1:0]  s_rem   [0:ROOT_W];
    logic [ROOT_W-1:0] s_root  [0:ROOT_W];
    logic [IN_W-1:0]   s_rad   [0:ROOT_W];
    logic [SIDE_W-1:0] s_side  [0:ROOT_W];

    assign s_valid[0] = i_valid;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_rad[0]   = i_radicand;
    assign s_side[0]  = i_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic              r_valid;
        logic [REM_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [IN_W-1:0]   r_rad;
        logic [SIDE_W-1:0] r_side;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              take;

        // Bring down the next two radicand bits and try the next root bit
        assign cur   = {s_rem[k][ROOT_W-1:0], s_rad[k][IN_W-1 -: 2]};
        assign trial = {s_root[k], 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= take ? (cur - trial) : cur;
                r_root <= {s_root[k][ROOT_W-2:0], take};
                r_rad  <= s_rad[k] << 2;
                r_side <= s_side[k];
            end
        end

        assign s_valid[k+1] = r_valid;
        assign s_rem[k+1]   = r_rem;
        assign s_root[k+1]  = r_root;
        assign s_rad[k+1]   = r_rad;
        assign s_side[k+1]  = r_side;
    end

    assign o_valid = s_valid[ROOT_W];
    assign o_root  = s_root[ROOT_W];
    assign o_side  = s_side[ROOT_W];

endmodule

>>> src/ptg_div.sv
// ============================================================================
// ptg_div: pipelined restoring divider
// One quotient bit per register stage. The caller supplies the upper part of
// the dividend as the starting remainder, which must be below the divisor.
// ============================================================================
module ptg_div import ptg_pkg::*; #(
    parameter int DEN_W  = 51,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [DEN_W-1:0]   i_rem,
    input  logic [QUOT_W-1:0]  i_low,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [QUOT_W-1:0]  o_quot,
    output logic [DEN_W-1:0]   o_rem,
    output logic [DEN_W-1:0]   o_den,
    output logic [SIDE_W-1:0]  o_side
);

    logic              s_valid [0:QUOT_W];
    logic [DEN_W-1:0]  s_rem   [0:QUOT_W];
    logic [QUOT_W-1:0] s_quot  [0:QUOT_W];
    logic [QUOT_W-1:0] s_low   [0:QUOT_W];
    logic [DEN_W-1:0]  s_den   [0:QUOT_W];
    logic [SIDE_W-1:0] s_side  [0:QUOT_W];

    assign s_valid[0] = i_valid;
    assign s_rem[0]   = i_rem;
    assign s_quot[0]  = '0;
    assign s_low[0]   = i_low;
    assign s_den[0]   = i_den;
    assign s_side[0]  = i_side;

    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        logic              r_valid;
        logic [DEN_W-1:0]  r_rem;
        logic [QUOT_W-1:0] r_quot;
        logic [QUOT_W-1:0] r_low;
        logic [DEN_W-1:0]  r_den;
        logic [SIDE_W-1:0] r_side;
        logic [DEN_W:0]    cur;
        logic [DEN_W:0]    dext;
        logic [DEN_W:0]    diff;
        logic              take;

        // Shift in one dividend bit and subtract the divisor when it fits
        assign cur  = {s_rem[k], s_low[k][QUOT_W-1]};
        assign dext = {1'b0, s_den[k]};
        assign diff = cur - dext;
        assign take = (cur >= dext);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= take ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
                r_quot <= {s_quot[k][QUOT_W-2:0], take};
                r_low  <= s_low[k] << 1;
                r_den  <= s_den[k];
                r_side <= s_side[k];
            end
        end

        assign s_valid[k+1] = r_valid;
        assign s_rem[k+1]   = r_rem;
        assign s_quot[k+1]  = r_quot;
        assign s_low[k+1]   = r_low;
        assign s_den[k+1]   = r_den;
        assign s_side[k+1]  = r_side;
    end

    assign o_valid = s_valid[QUOT_W];
    assign o_quot  = s_quot[QUOT_W];
    assign o_rem   = s_rem[QUOT_W];
    assign o_den   = s_den[QUOT_W];
    assign o_side  = s_side[QUOT_W];

endmodule

>>> bench/tb_periodic_triangle_geometry_core.sv
// ============================================================================
// tb_periodic_triangle_geometry_core: self-checking bench for the geometry core
// Streams triangles through the core under several box lengths, predicts
// every result with a bit-exact integer model and checks each field in order,
// with random gaps on the request side and random stalls on the result side.
// ============================================================================
module tb_periodic_triangle_geometry_core;
    import ptg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 24;
    localparam int LATENCY = 94;

    typedef struct {
        logic [CW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
    } tri_t;

    typedef struct {
        logic [AREA_W-1:0] area;
        logic [NORM_W-1:0] nx, ny, nz;
        logic [COT_W-1:0]  cot;
        logic [EDGE_W-1:0] edge_len;
        logic              degen;
    } geom_t;

    // Predicts the core's results and holds them until they come out
    class geometry_scoreboard;
        logic [BOX_W-1:0] box_x, box_y;
        geom_t pending[$];
        int errors;

        function new();
            box_x = BOX_RESET;
            box_y = BOX_RESET;
            errors = 0;
        endfunction

        task report(string what, logic [127:0] got, logic [127:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // Wrap a fractional difference to its minimum image, scale by the box
        function automatic logic signed [127:0] wrap_scale(logic [CW-1:0] from,
                logic [CW-1:0] to, logic [BOX_W-1:0] box);
            logic signed [CW-1:0] d;
            logic signed [127:0] p;
            logic [127:0] m;
            d = to - from;
            p = $signed({104'd0, box}) * 128'(d);
            m = ((p < 0 ? -p : p) + (128'd1 << (CW - 1))) >> CW;
            return p < 0 ? -$signed(m) : $signed(m);
        endfunction

        function automatic logic [127:0] root(logic [127:0] x);
            logic [127:0] r, b, rem;
            rem = x;
            r = 0;
            b = 128'd1 << 126;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (rem >= r + b) begin
                    rem -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
            logic [127:0] q, rem;
            q = n / d;
            rem = n % d;
            if (rem >= d - rem) q++;
            return q;
        endfunction

        function automatic logic [127:0] mag(logic signed [127:0] v);
            return v < 0 ? -v : v;
        endfunction

        function automatic logic [NORM_W-1:0] unit_part(logic signed [127:0] c,
                logic [127:0] m);
            logic [127:0] q;
            q = div_round(mag(c) << NORM_FRAC, m);
            return c < 0 ? NORM_W'(-q) : NORM_W'(q);
        endfunction

        // Compute the expected result of one accepted request
        function void note_request(tri_t t);
            logic signed [127:0] ax, ay, az, bx, by, bz, cx, cy, cz, dot;
            logic [127:0] m, e, q;
            geom_t g;
            ax = wrap_scale(t.x1, t.x2, box_x);
            ay = wrap_scale(t.y1, t.y2, box_y);
            az = 128'($signed(t.z2)) - 128'($signed(t.z1));
            bx = wrap_scale(t.x1, t.x3, box_x);
            by = wrap_scale(t.y1, t.y3, box_y);
            bz = 128'($signed(t.z3)) - 128'($signed(t.z1));
            cx = ay * bz - az * by;
            cy = az * bx - ax * bz;
            cz = ax * by - ay * bx;
            m = root(cx * cx + cy * cy + cz * cz);
            e = root(ax * ax + ay * ay + az * az);
            g = '{default: '0};
            g.edge_len = e > 128'hFFFF_FFFF ? '1 : e[EDGE_W-1:0];
            if (m == 0) begin
                g.degen = 1'b1;
            end else begin
                q = (m + (128'd1 << 16)) >> AREA_SHIFT;
                g.area = q > 128'hFFFF_FFFF_FFFF ? '1 : q[AREA_W-1:0];
                g.nx = unit_part(cx, m);
                g.ny = unit_part(cy, m);
                g.nz = unit_part(cz, m);
                dot = ax * bx + ay * by + az * bz;
                q = div_round(mag(dot) << COT_FRAC, m);
                if (dot < 0)
                    g.cot = q > 128'h8000_0000 ? COT_MIN : COT_W'(-q);
                else
                    g.cot = q > 128'h7FFF_FFFF ? COT_MAX : q[COT_W-1:0];
            end
            pending.push_back(g);
        endfunction

        task check_result(geom_t got);
            geom_t want;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.area !== want.area) report("area", got.area, want.area);
            if (got.nx !== want.nx) report("normal_x", got.nx, want.nx);
            if (got.ny !== want.ny) report("normal_y", got.ny, want.ny);
            if (got.nz !== want.nz) report("normal_z", got.nz, want.nz);
            if (got.cot !== want.cot) report("cotangent", got.cot, want.cot);
            if (got.edge_len !== want.edge_len)
                report("edge_length", got.edge_len, want.edge_len);
            if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BOX_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic [CW-1:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic [CW-1:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic [CW-1:0] i_third_x = '0, i_third_y = '0, i_third_z = '0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid, o_degenerate;
    logic [AREA_W-1:0] o_area;
    logic signed [NORM_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic signed [COT_W-1:0] o_cotangent;
    logic [EDGE_W-1:0] o_edge_length;

    geometry_scoreboard board = new();
    int stall_left = 0;

    periodic_triangle_geometry_core #(.COORD_WIDTH(CW)) dut (.*);

    always #1 i_clk = ~i_clk;

    // Stall the result side at random, now and then for long stretches
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_out_ready <= 1'b1;
            end else if (r < 95) begin
                i_out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                stall_left <= $urandom_range(10, 60);
            end
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result('{o_area, o_normal_x, o_normal_y, o_normal_z,
                                 o_cotangent, o_edge_length, o_degenerate});
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold the request until accepted, then idle for a random gap
    task send_triangle(tri_t t);
        int gap;
        i_in_valid <= 1'b1;
        {i_first_x, i_first_y, i_first_z} <= {t.x1, t.y1, t.z1};
        {i_second_x, i_second_y, i_second_z} <= {t.x2, t.y2, t.z2};
        {i_third_x, i_third_y, i_third_z} <= {t.x3, t.y3, t.z3};
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(t);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task write_box(t_cfg_reg idx, logic [BOX_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_BOX_X) board.box_x = value;
        else board.box_y = value;
    endtask

    // Drain the pipeline before touching the box lengths
    task drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic tri_t random_triangle();
        tri_t t;
        int r;
        t = '{CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
              CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom)};
        r = $urandom_range(0, 9);
        // Keep vertices close so the wrap rarely kicks in
        if (r < 3) begin
            t.x2 = t.x1 + CW'($urandom_range(0, 4095)) - CW'(2048);
            t.y2 = t.y1 + CW'($urandom_range(0, 4095)) - CW'(2048);
            t.x3 = t.x1 + CW'($urandom_range(0, 4095)) - CW'(2048);
            t.y3 = t.y1 + CW'($urandom_range(0, 4095)) - CW'(2048);
            t.z2 = t.z1 + CW'($urandom_range(0, 4095)) - CW'(2048);
            t.z3 = t.z1 + CW'($urandom_range(0, 4095)) - CW'(2048);
        end else if (r == 3) begin
            // Repeat a vertex: degenerate
            {t.x3, t.y3, t.z3} = {t.x1, t.y1, t.z1};
        end else if (r == 4) begin
            // Collinear: vertex three doubles edge one
            t.x3 = t.x1 + ((t.x2 - t.x1) << 1);
            t.y3 = t.y1 + ((t.y2 - t.y1) << 1);
            t.z3 = t.z1 + ((t.z2 - t.z1) << 1);
        end else if (r == 5) begin
            // Flat triangle in the z plane
            t.z2 = t.z1;
            t.z3 = t.z1;
        end
        return t;
    endfunction

    localparam logic [CW-1:0] HALF = 24'h800000;
    localparam logic [CW-1:0] ONES = 24'hFFFFFF;

    initial begin
        tri_t directed[$];
        logic [BOX_W-1:0] boxes[6][2];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zeros, extremes, half wrap, opposite heights, right angle, collinear
        directed = '{
            '{0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES},
            '{0, 0, 0, HALF, 0, 0, 0, HALF, 0},
            '{0, 0, 24'h7FFFFF, HALF, HALF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF},
            '{0, 0, 24'h800000, ONES, 0, 24'h7FFFFF, 0, ONES, 24'h800000},
            '{0, 0, 0, 24'h100000, 0, 0, 0, 24'h100000, 0},
            '{0, 0, 0, 24'h100000, 0, 0, 24'h200000, 0, 0},
            '{24'h400000, 0, 0, 24'hC00000, 0, 0, 0, 24'h000001, 0},
            '{0, 0, 0, 0, 0, 24'h7FFFFF, 0, 0, 24'h800000},
            '{0, 0, 0, 0, 0, 24'h7FFFFF, 24'h000001, 0, 24'h800000},
            '{0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 0, 24'h800001, 24'h800001, 0},
            '{ONES, 0, 0, 0, ONES, 0, 1, 1, 24'h000001},
            '{0, 0, 0, 24'h000001, 0, 0, 0, 24'h000001, 0},
            '{HALF, HALF, 0, 0, 0, 24'h010000, HALF, 0, 24'hFF0000}
        };
        boxes = '{'{BOX_RESET, BOX_RESET}, '{24'd1, ONES}, '{ONES, 24'd1},
                  '{ONES, ONES}, '{24'd1, 24'd1}, '{24'd0, 24'd0}};

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                if (ph == 5) begin
                    boxes[5][0] = BOX_W'($urandom_range(1, 24'hFFFFFF));
                    boxes[5][1] = BOX_W'($urandom_range(1, 24'hFFFFFF));
                end
                write_box(REG_BOX_X, boxes[ph][0]);
                write_box(REG_BOX_Y, boxes[ph][1]);
            end
            foreach (directed[k]) send_triangle(directed[k]);
            repeat (240) send_triangle(random_triangle());
        end

        drain();
        if (board.pending.size() != 0) board.report("missing results", 0, 0);
        if (board.errors == 0)
            $display("tb_periodic_triangle_geometry_core passed");
        else
            $display("tb_periodic_triangle_geometry_core failed");
        $finish;
    end

    // Stop a hung run
    initial begin
        #4ms;
        $display("tb_periodic_triangle_geometry_core failed");
        $finish;
    end

endmodule
